// ===== hw/rtl/fdm_pkg.sv =====
`timescale 1ns / 1ps
package fdm_pkg;

  typedef logic [7:0]        pix8_t;
  typedef logic signed [8:0] gdiff_t;
  typedef logic [14:0]       gsum_t;

  // gray = (30r + 59g + 11b) / 100, the divide done as * 5243 >> 19
  localparam int unsigned COEF_R     = 30;
  localparam int unsigned COEF_G     = 59;
  localparam int unsigned COEF_B     = 11;
  localparam int unsigned GRAY_MUL   = 5243;
  localparam int unsigned GRAY_SHIFT = 19;
  localparam int unsigned GRAY_MUL_W = 13;
  localparam int unsigned GRAY_PROD_W = $bits(gsum_t) + GRAY_MUL_W;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  typedef enum logic {
    REG_MOTION_THRESHOLD = 1'b0,
    REG_UNMAPPED         = 1'b1
  } reg_idx_t;

  localparam pix8_t THRESHOLD_RESET = 8'd23;

endpackage

// ===== hw/rtl/fdm_pix_in_if.sv =====
`timescale 1ns / 1ps
interface fdm_pix_in_if;
  import fdm_pkg::*;

  logic  valid;
  logic  ready;
  pix8_t red;
  pix8_t green;
  pix8_t blue;
  logic  frame_end;

  modport source (output valid, output red, output green, output blue,
                  output frame_end, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input frame_end, output ready);
endinterface

// ===== hw/rtl/fdm_res_out_if.sv =====
`timescale 1ns / 1ps
interface fdm_res_out_if;
  import fdm_pkg::*;

  logic   valid;
  logic   ready;
  logic   motion;
  gdiff_t gray_difference;
  logic   frame_done;

  modport source (output valid, output motion, output gray_difference,
                  output frame_done, input ready);
  modport sink   (input valid, input motion, input gray_difference,
                  input frame_done, output ready);
endinterface

// ===== hw/rtl/fdm_ram.sv =====
`timescale 1ns / 1ps
module fdm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/frame_difference_motion_mask_core.sv =====
`timescale 1ns / 1ps
// Frame-difference motion mask. RGB pixels arrive in raster order, one beat per
// pixel, frame_end on the last pixel of each frame. Each pixel is reduced to gray
// (30r+59g+11b)/100, truncated. The first frame after reset is stored in an
// on-chip reference RAM of MAX_PIXELS x 8 bits and reports difference 0; every
// later frame reports current minus reference gray and flags motion when that
// exceeds motion_threshold (APB register 0, reset 23). The reference is never
// refreshed; pixels past MAX_PIXELS are not stored and report 0. The core takes
// one pixel per clock while the output is not stalled. The reference RAM read
// and stage 1 register at the accepting edge, and the output register loads
// when the output can advance. The RAM needs no clearing after reset, so
// pixels are taken from the first cycle.
module frame_difference_motion_mask_core #(
  parameter int unsigned MAX_PIXELS = 32768
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [fdm_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [fdm_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [fdm_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready,
  fdm_pix_in_if.sink                  in_pix,
  fdm_res_out_if.source               out_res
);
  import fdm_pkg::*;

  localparam int unsigned PW = $clog2(MAX_PIXELS + 1);
  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_PIXELS);

  // ---------------- configuration ----------------
  pix8_t    thr_r;
  reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (cfg_idx)
        REG_MOTION_THRESHOLD: thr_r <= cfg_pwdata[7:0];
        REG_UNMAPPED:         thr_r <= thr_r;
        default:              thr_r <= thr_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MOTION_THRESHOLD: cfg_prdata = {(CFG_DW - 8)'(0), thr_r};
      default:              cfg_prdata = '0;
    endcase
  end

  // ---------------- frame position ----------------
  logic          pos_in_range;
  logic          in_fire;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          ref_ready_r, ref_ready_nxt;

  assign pos_in_range = pos_r < POS_LIMIT;

  always_comb begin
    pos_nxt       = pos_r;
    ref_ready_nxt = ref_ready_r;
    if (in_fire) begin
      if (in_pix.frame_end) begin
        pos_nxt       = '0;
        ref_ready_nxt = 1'b1;
      end else if (pos_in_range) begin
        pos_nxt = pos_r + PW'(1);
      end
    end
  end

  // ---------------- stage 1: weighted sum, RAM read ----------------
  logic          adv;
  logic          s1_valid_r;
  gsum_t         s1_sum_r;
  logic          s1_last_r;
  logic          s1_cmp_r;
  logic          s1_wr_r;
  logic [AW-1:0] s1_addr_r;
  logic          s1_fwd_r;
  pix8_t         s1_fwd_data_r;

  gsum_t         in_sum;
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] rd_addr;
  pix8_t         ram_rdata;

  assign adv          = !out_res.valid || out_res.ready;
  assign in_pix.ready = !s1_valid_r || adv;
  assign in_fire      = in_pix.valid && in_pix.ready;
  assign rd_addr      = pos_r[AW-1:0];

  assign in_sum = gsum_t'(COEF_R) * gsum_t'(in_pix.red)
                + gsum_t'(COEF_G) * gsum_t'(in_pix.green)
                + gsum_t'(COEF_B) * gsum_t'(in_pix.blue);

  assign ram_re = in_fire && ref_ready_r && pos_in_range;

  // ---------------- stage 2: gray, difference, write back ----------------
  logic [GRAY_PROD_W-1:0] gray_prod;
  pix8_t                  gray;
  pix8_t                  ref_gray;
  gdiff_t                 diff;
  logic                   motion;

  assign gray_prod = GRAY_PROD_W'(s1_sum_r) * GRAY_PROD_W'(GRAY_MUL);
  assign gray      = gray_prod[GRAY_SHIFT +: 8];
  assign ref_gray  = s1_fwd_r ? s1_fwd_data_r : ram_rdata;
  assign diff      = s1_cmp_r ? gdiff_t'({1'b0, gray} - {1'b0, ref_gray}) : '0;
  assign motion    = s1_cmp_r && ($signed({diff[8], diff}) > $signed({2'b00, thr_r}));
  assign ram_we    = s1_valid_r && adv && s1_wr_r;

  fdm_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PIXELS)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (gray),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  logic   out_valid_r;
  logic   out_motion_r;
  gdiff_t out_gdiff_r;
  logic   out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      ref_ready_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      ref_ready_r <= ref_ready_nxt;
      if (in_pix.ready) begin
        s1_valid_r <= in_fire;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sum_r  <= in_sum;
      s1_last_r <= in_pix.frame_end;
      s1_cmp_r  <= ref_ready_r && pos_in_range;
      s1_wr_r   <= !ref_ready_r && pos_in_range;
      s1_addr_r <= rd_addr;
      // catch a write to the entry being read this same edge
      s1_fwd_r      <= ram_we && (s1_addr_r == rd_addr);
      s1_fwd_data_r <= gray;
    end
    if (adv && s1_valid_r) begin
      out_motion_r <= motion;
      out_gdiff_r  <= diff;
      out_done_r   <= s1_last_r;
    end
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.motion          = out_motion_r;
  assign out_res.gray_difference = out_gdiff_r;
  assign out_res.frame_done      = out_done_r;

  // ---------------- assertions ----------------
  a_fwd_only_compare: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_fwd_r |-> s1_cmp_r)
    else $error("forwarded reference on a non-compare pixel");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |-> !in_pix.ready)
    else $error("input taken while stage 1 is held");

  a_motion_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_motion_r |-> !out_gdiff_r[8] && (out_gdiff_r != '0))
    else $error("motion flagged without brightening");

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LIMIT)
    else $error("pixel position past capacity");

endmodule
